// ----- rtl/hrrn_pkg.sv -----
// Shared types and constants of the response-ratio batch scheduler.
// No dependencies; hrrn_div and the core refer to it by scoped names.
`default_nettype none

package hrrn_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int ARR_W         = 16;
   localparam int BUR_W         = 16;
   localparam int TIME_W        = 21;
   localparam int NORM_W        = 29;
   localparam int FRAC_W        = 8;
   localparam int IDX_OUT_W     = 4;

   typedef struct packed {
      logic [ARR_W-1:0] arrival_time;
      logic [BUR_W-1:0] burst_time;
      logic             last_job;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] job_index;
      logic [TIME_W-1:0]    wait_time;
      logic [TIME_W-1:0]    turnaround_time;
      logic [NORM_W-1:0]    normalized_turnaround;
      logic                 last_result;
   } rsp_type;

   // completed job handed to the divider
   typedef struct packed {
      logic [IDX_OUT_W-1:0] job_index;
      logic [TIME_W-1:0]    wait_time;
      logic [TIME_W-1:0]    turnaround_time;
      logic [BUR_W-1:0]     burst_time;
      logic                 last_result;
   } div_req_type;

endpackage

`default_nettype wire

// ----- rtl/hrrn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hrrn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hrrn_div.sv -----
// Restoring divider for the normalized turnaround, one quotient bit per cycle,
// and the result register of the block. Depends on hrrn_pkg.
`default_nettype none

module hrrn_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire hrrn_pkg::div_req_type req,
   output      logic                 busy,
   output      logic                 rsp_strobe,
   output      hrrn_pkg::rsp_type    rsp
);

   localparam int NW = hrrn_pkg::NORM_W;
   localparam int BW = hrrn_pkg::BUR_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic                  busy_ff, busy_in;
   logic                  strobe_ff, strobe_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [NW-1:0]         quo_ff, quo_in;
   logic [BW-1:0]         rem_ff, rem_in;
   hrrn_pkg::div_req_type job_ff, job_in;

   logic [BW:0] trial;
   logic        ge;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign ge    = trial >= {1'b0, job_ff.burst_time};

   always_comb begin
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      job_in    = job_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW);
         // dividend is turnaround scaled by the fraction bits
         quo_in  = {req.turnaround_time, hrrn_pkg::FRAC_W'(0)};
         rem_in  = '0;
         job_in  = req;
      end else if (busy_ff) begin
         rem_in = ge ? BW'(trial - {1'b0, job_ff.burst_time}) : trial[BW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in   = 1'b0;
            strobe_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      job_ff <= job_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   always_comb begin
      rsp.job_index             = job_ff.job_index;
      rsp.wait_time             = job_ff.wait_time;
      rsp.turnaround_time       = job_ff.turnaround_time;
      rsp.normalized_turnaround = quo_ff;
      rsp.last_result           = job_ff.last_result;
   end

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("two result beats in a row from divider");
`endif

endmodule

`default_nettype wire

// ----- rtl/hrrn_batch_scheduler_core.sv -----
// Top level of the response-ratio batch scheduler: loader, scan sequencer and
// pick logic around the job RAM. Depends on hrrn_pkg, hrrn_ram and hrrn_div.
//
// Usage:
//   A job is taken on a rising edge with start high and busy low; req_data
//   carries arrival time, burst time and the last_job mark. Jobs load one per
//   cycle into the job RAM; a job beyond MAX_PROCS is dropped. The beat that
//   carries last_job starts the pass, and busy stays high up to the cycle that
//   carries the final result beat; a new job may be taken in that cycle.
//   Each completed job gives one beat on rsp_data, marked by rsp_strobe for
//   exactly one cycle, in completion order. The receiver cannot stall.
//   Sequence: each loaded job is written to the job RAM, then S_ISSUE issues the
//   first read. Each pick scans all n stored entries through the RAM read port,
//   with an extra S_CMP step for every arrived entry that is cross-multiplied
//   against the held best, then S_DECIDE and S_FIN close the pick; an idle gap,
//   including a first scan at time zero, adds an S_DECIDE step and one more scan.
//   The bit-serial divider for the 29-bit normalized turnaround runs alongside
//   the next scan, so a pick waits only while the previous division is running.
//   Synchronous reset clears the job count, done flags, time and all control;
//   the RAM contents are not cleared and need no sweep.
`default_nettype none

module hrrn_batch_scheduler_core #(
   parameter int MAX_PROCS = hrrn_pkg::MAX_PROCS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire hrrn_pkg::req_type req_data,
   output      logic              busy,
   output      logic              rsp_strobe,
   output      hrrn_pkg::rsp_type rsp_data
);

   localparam int IW     = $clog2(MAX_PROCS);
   localparam int CW     = $clog2(MAX_PROCS + 1);
   localparam int AW     = hrrn_pkg::ARR_W;
   localparam int BW     = hrrn_pkg::BUR_W;
   localparam int TW     = hrrn_pkg::TIME_W;
   localparam int RA_W   = TW + 1;
   localparam int PROD_W = RA_W + BW;
   localparam int WORD_W = AW + BW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ISSUE  = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        job_count_ff, job_count_in;
   logic [CW-1:0]        pick_cnt_ff, pick_cnt_in;
   logic [TW-1:0]        ct_ff, ct_in;
   logic [IW-1:0]        scan_idx_ff, scan_idx_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic                 have_best_ff, have_best_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [AW-1:0]        best_arr_ff, best_arr_in;
   logic [BW-1:0]        best_bur_ff, best_bur_in;
   logic [RA_W-1:0]      best_ra_ff, best_ra_in;
   logic [AW-1:0]        min_arr_ff, min_arr_in;
   logic [PROD_W-1:0]    prod_l_ff, prod_l_in;
   logic [PROD_W-1:0]    prod_r_ff, prod_r_in;

   logic                  ram_wr_en;
   logic [WORD_W-1:0]     ram_wr_data;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [AW-1:0]         rd_arr;
   logic [BW-1:0]         rd_bur;
   logic [RA_W-1:0]       cur_ra;
   logic                  not_done;
   logic                  eligible;
   logic                  scan_last;
   logic                  room;
   logic                  take;
   logic [TW:0]           ct_sum;
   logic [TW-1:0]         tt_c;
   logic [TW-1:0]         wt_c;
   logic                  div_start;
   logic                  div_busy;
   hrrn_pkg::div_req_type div_req;

   assign rd_arr    = ram_rd_data[WORD_W-1:BW];
   assign rd_bur    = ram_rd_data[BW-1:0];
   assign cur_ra    = RA_W'(ct_ff) - RA_W'(rd_arr) + RA_W'(rd_bur);
   assign not_done  = !done_ff[scan_idx_ff];
   assign eligible  = not_done && (TW'(rd_arr) <= ct_ff);
   assign scan_last = CW'(scan_idx_ff) == (job_count_ff - CW'(1));
   assign room      = job_count_ff < CW'(MAX_PROCS);
   assign take      = (prod_l_ff > prod_r_ff)
                      || ((prod_l_ff == prod_r_ff) && (rd_arr < best_arr_ff));
   assign ct_sum    = (TW + 1)'(ct_ff) + (TW + 1)'(best_bur_ff);
   assign tt_c      = ct_ff - TW'(best_arr_ff);
   assign wt_c      = (tt_c >= TW'(best_bur_ff)) ? (tt_c - TW'(best_bur_ff)) : '0;

   assign ram_wr_en   = (state_ff == S_IDLE) && start && !div_busy && room;
   assign ram_wr_data = {req_data.arrival_time,
                         (req_data.burst_time == '0) ? BW'(1) : req_data.burst_time};

   always_comb begin
      div_req.job_index       = hrrn_pkg::IDX_OUT_W'(best_idx_ff);
      div_req.wait_time       = wt_c;
      div_req.turnaround_time = tt_c;
      div_req.burst_time      = best_bur_ff;
      div_req.last_result     = pick_cnt_ff == job_count_ff;
   end

   always_comb begin
      state_in     = state_ff;
      job_count_in = job_count_ff;
      pick_cnt_in  = pick_cnt_ff;
      ct_in        = ct_ff;
      scan_idx_in  = scan_idx_ff;
      done_in      = done_ff;
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      best_ra_in   = best_ra_ff;
      min_arr_in   = min_arr_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            scan_idx_in = '0;
            if (start && !div_busy) begin
               if (room) begin
                  job_count_in = job_count_ff + CW'(1);
               end
               if (req_data.last_job) begin
                  have_best_in = 1'b0;
                  min_arr_in   = '1;
                  state_in     = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            // read entry zero once the last write has landed
            scan_idx_in = '0;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            if (not_done && (rd_arr < min_arr_ff)) begin
               min_arr_in = rd_arr;
            end
            if (eligible && have_best_ff) begin
               prod_l_in = PROD_W'(cur_ra) * PROD_W'(best_bur_ff);
               prod_r_in = PROD_W'(best_ra_ff) * PROD_W'(rd_bur);
               state_in  = S_CMP;
            end else begin
               if (eligible) begin
                  have_best_in = 1'b1;
                  best_idx_in  = scan_idx_ff;
                  best_arr_in  = rd_arr;
                  best_bur_in  = rd_bur;
                  best_ra_in   = cur_ra;
               end
               if (scan_last) begin
                  scan_idx_in = '0;
                  state_in    = S_DECIDE;
               end else begin
                  scan_idx_in = scan_idx_ff + IW'(1);
               end
            end
         end
         S_CMP: begin
            if (take) begin
               best_idx_in = scan_idx_ff;
               best_arr_in = rd_arr;
               best_bur_in = rd_bur;
               best_ra_in  = cur_ra;
            end
            if (scan_last) begin
               scan_idx_in = '0;
               state_in    = S_DECIDE;
            end else begin
               scan_idx_in = scan_idx_ff + IW'(1);
               state_in    = S_EVAL;
            end
         end
         S_DECIDE: begin
            scan_idx_in = '0;
            if (!have_best_ff) begin
               // nothing has arrived: jump to the earliest pending arrival, rescan
               ct_in        = TW'(min_arr_ff);
               min_arr_in   = '1;
               state_in     = S_EVAL;
            end else begin
               ct_in               = ct_sum[TW] ? '1 : ct_sum[TW-1:0];
               done_in[best_idx_ff] = 1'b1;
               pick_cnt_in         = pick_cnt_ff + CW'(1);
               state_in            = S_FIN;
            end
         end
         S_FIN: begin
            scan_idx_in = '0;
            // hold until the divider can take this job
            if (!div_busy) begin
               div_start    = 1'b1;
               have_best_in = 1'b0;
               min_arr_in   = '1;
               if (pick_cnt_ff == job_count_ff) begin
                  job_count_in = '0;
                  pick_cnt_in  = '0;
                  ct_in        = '0;
                  done_in      = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_count_ff <= '0;
         pick_cnt_ff  <= '0;
         ct_ff        <= '0;
         scan_idx_ff  <= '0;
         done_ff      <= '0;
         have_best_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_count_ff <= job_count_in;
         pick_cnt_ff  <= pick_cnt_in;
         ct_ff        <= ct_in;
         scan_idx_ff  <= scan_idx_in;
         done_ff      <= done_in;
         have_best_ff <= have_best_in;
      end
      best_idx_ff <= best_idx_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      best_ra_ff  <= best_ra_in;
      min_arr_ff  <= min_arr_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
   end

   hrrn_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_PROCS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (job_count_ff[IW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (scan_idx_in),
      .rd_data (ram_rd_data)
   );

   hrrn_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .req        (div_req),
      .busy       (div_busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   assign busy = (state_ff != S_IDLE) || div_busy;

`ifndef SYNTHESIS
   a_pass_has_jobs: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (job_count_ff != '0))
      else $error("scheduling pass running with no stored jobs");
   a_picks_bounded: assert property (@(posedge clock) disable iff (reset)
      pick_cnt_ff <= job_count_ff)
      else $error("more picks than stored jobs");
   a_pick_not_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DECIDE) && have_best_ff) |-> !done_ff[best_idx_ff])
      else $error("picked a job that already completed");
   a_fin_marks_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (done_ff[best_idx_ff] || (state_in == S_IDLE)))
      else $error("closing a pick whose done flag is not set");
`endif

endmodule

`default_nettype wire
